### rtl/iira_pkg.sv
// ============================================================================
// iira_pkg: shared types, constants and microprogram for the radix converter
// Holds the item structs, the radix codes, the digit table and the control
// store that sequences conversion and character emission.
// ============================================================================
`default_nettype none

package iira_pkg;

    // Width of the input integer and the default number of bits converted.
    localparam int VALUE_WIDTH      = 63;
    localparam int VALUE_BITS_DEF   = 63;

    // Radix codes carried in the func field.
    localparam logic [1:0] FUNC_OCT = 2'd0;
    localparam logic [1:0] FUNC_DEC = 2'd1;
    localparam logic [1:0] FUNC_HEX = 2'd2;

    // Characters other than digits.
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_X    = 7'h78;

    // Lower-case digit characters, indexed by the digit value.
    localparam logic [6:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [1:0]             func;
    } cmd_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
    } result_t;

    // Datapath operations.
    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_LOAD       = 3'd1;
    localparam logic [2:0] OP_SHIFT      = 3'd2;
    localparam logic [2:0] OP_EMIT_ZERO  = 3'd3;
    localparam logic [2:0] OP_EMIT_X     = 3'd4;
    localparam logic [2:0] OP_DROP       = 3'd5;
    localparam logic [2:0] OP_EMIT_DIGIT = 3'd6;

    // Jump conditions.
    localparam logic [2:0] COND_NEVER       = 3'd0;
    localparam logic [2:0] COND_ALWAYS      = 3'd1;
    localparam logic [2:0] COND_NO_START    = 3'd2;
    localparam logic [2:0] COND_BAD_FUNC    = 3'd3;
    localparam logic [2:0] COND_MORE_BITS   = 3'd4;
    localparam logic [2:0] COND_NOT_HEX     = 3'd5;
    localparam logic [2:0] COND_LEAD_ZERO   = 3'd6;
    localparam logic [2:0] COND_MORE_DIGITS = 3'd7;

    // Step addresses of the microprogram.
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_CHKF = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_CONV = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_HEXQ = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_PFX0 = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_PFXX = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_SKIP = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_EMIT = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_DONE = 4'd8;

    typedef struct packed {
        logic [2:0]           op;
        logic [2:0]           cond;
        logic [STEP_BITS-1:0] target;
    } ucode_t;

    // The control store: one word per step. When the condition holds the
    // sequencer jumps to the target, otherwise it falls through.
    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t w;
        case (step)
            STEP_IDLE: w = '{OP_LOAD,       COND_NO_START,    STEP_IDLE};
            STEP_CHKF: w = '{OP_NONE,       COND_BAD_FUNC,    STEP_IDLE};
            STEP_CONV: w = '{OP_SHIFT,      COND_MORE_BITS,   STEP_CONV};
            STEP_HEXQ: w = '{OP_NONE,       COND_NOT_HEX,     STEP_SKIP};
            STEP_PFX0: w = '{OP_EMIT_ZERO,  COND_NEVER,       STEP_IDLE};
            STEP_PFXX: w = '{OP_EMIT_X,     COND_NEVER,       STEP_IDLE};
            STEP_SKIP: w = '{OP_DROP,       COND_LEAD_ZERO,   STEP_SKIP};
            STEP_EMIT: w = '{OP_EMIT_DIGIT, COND_MORE_DIGITS, STEP_EMIT};
            STEP_DONE: w = '{OP_NONE,       COND_ALWAYS,      STEP_IDLE};
            default:   w = '{OP_NONE,       COND_ALWAYS,      STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/integer_to_radix_ascii.sv
// The characters of an item come out after the bit-serial conversion loop, the 0x prefix for
// hex and the leading zero skip. A new item is taken only once the last one is finished (busy
// is low); an unused radix code ends the item at the radix check step with no characters.
// The receiver cannot stall: each character is on the result ports for exactly one cycle.
// Reset returns the sequencer to its idle step and clears the result strobe.
// ============================================================================
// integer_to_radix_ascii: integer to octal, decimal or hexadecimal text
// A microcoded sequencer converts the integer bit-serially into a chain of
// radix digits, then emits them most significant first as ASCII, hex after a 0x prefix.
// ============================================================================
`default_nettype none

module integer_to_radix_ascii #(
    parameter int VALUE_BITS = iira_pkg::VALUE_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire iira_pkg::cmd_t   cmd,
    output logic                  result_valid,
    output iira_pkg::result_t     result
);

    import iira_pkg::*;

    // Octal needs the most digits, so it sizes the digit chain.
    localparam int NDIG = (VALUE_BITS + 2) / 3;
    localparam int DW   = 4 * NDIG;
    localparam int BCW  = $clog2(VALUE_BITS + 1);
    localparam int RW   = $clog2(NDIG + 1);

    // Sequencer state.
    logic [STEP_BITS-1:0]  pc_reg, pc_next;
    ucode_t                uword;
    logic                  cond_true;

    // Datapath registers.
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [DW-1:0]         digits_reg, digits_next;
    logic [1:0]            func_reg, func_next;
    logic [BCW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg, result_next;

    // Derived datapath signals.
    logic                  accept;
    logic [3:0]            top_digit;
    logic                  lead_zero;
    logic                  last_digit;
    logic [3:0]            half;
    logic [3:0]            adj;
    logic [DW-1:0]         corrected;

    assign uword      = ucode_rom(pc_reg);
    assign busy       = (pc_reg != STEP_IDLE);
    assign accept     = start && !busy;
    assign top_digit  = digits_reg[DW-1 -: 4];
    assign last_digit = (rem_reg == RW'(1));
    assign lead_zero  = (top_digit == 4'd0) && !last_digit;

    // A digit of radix r is doubled with carry by first adding (16 - r) / 2
    // when it is at least r / 2, then shifting the whole chain one place.
    always_comb
    begin
        case (func_reg)
            FUNC_OCT:
            begin
                half = 4'd4;
                adj  = 4'd4;
            end
            FUNC_DEC:
            begin
                half = 4'd5;
                adj  = 4'd3;
            end
            default:
            begin
                half = 4'd8;
                adj  = 4'd0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (digits_reg[4*i +: 4] >= half)
                corrected[4*i +: 4] = digits_reg[4*i +: 4] + adj;
            else
                corrected[4*i +: 4] = digits_reg[4*i +: 4];
        end
    end

    // Jump condition selected by the current control word.
    always_comb
    begin
        case (uword.cond)
            COND_NEVER:       cond_true = 1'b0;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_NO_START:    cond_true = !start;
            COND_BAD_FUNC:    cond_true = !(func_reg inside {FUNC_OCT, FUNC_DEC, FUNC_HEX});
            COND_MORE_BITS:   cond_true = (bit_cnt_reg != BCW'(1));
            COND_NOT_HEX:     cond_true = (func_reg != FUNC_HEX);
            COND_LEAD_ZERO:   cond_true = lead_zero;
            COND_MORE_DIGITS: cond_true = !last_digit;
            default:          cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uword.target : pc_reg + STEP_BITS'(1);
    end

    // Datapath operations selected by the current control word.
    always_comb
    begin
        value_next        = value_reg;
        digits_next       = digits_reg;
        func_next         = func_reg;
        bit_cnt_next      = bit_cnt_reg;
        rem_next          = rem_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        case (uword.op)
            OP_LOAD:
            begin
                // Only the accepting cycle loads; bits above VALUE_BITS are dropped.
                if (start)
                begin
                    value_next   = cmd.value[VALUE_BITS-1:0];
                    func_next    = cmd.func;
                    digits_next  = '0;
                    bit_cnt_next = BCW'(VALUE_BITS);
                    rem_next     = RW'(NDIG);
                end
            end
            OP_SHIFT:
            begin
                digits_next  = {corrected[DW-2:0], value_reg[VALUE_BITS-1]};
                value_next   = {value_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BCW'(1);
            end
            OP_EMIT_ZERO:
            begin
                result_valid_next     = 1'b1;
                result_next.char_code = CHAR_ZERO;
                result_next.last      = 1'b0;
            end
            OP_EMIT_X:
            begin
                result_valid_next     = 1'b1;
                result_next.char_code = CHAR_X;
                result_next.last      = 1'b0;
            end
            OP_DROP:
            begin
                // Leading zeros are discarded, but the final digit always stays.
                if (lead_zero)
                begin
                    digits_next = {digits_reg[DW-5:0], 4'd0};
                    rem_next    = rem_reg - RW'(1);
                end
            end
            OP_EMIT_DIGIT:
            begin
                result_valid_next     = 1'b1;
                result_next.char_code = DIGIT_CHARS[top_digit];
                result_next.last      = last_digit;
                digits_next           = {digits_reg[DW-5:0], 4'd0};
                rem_next              = rem_reg - RW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= STEP_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg           <= pc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        digits_reg  <= digits_next;
        func_reg    <= func_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // A character is only ever delivered while an item is in progress.
    a_result_in_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside an item");

    // The final character of a string is never followed at once by another.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("character after the last one");

    // An accepted item always enters the radix check step next.
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pc_reg == STEP_CHKF))
        else $error("sequencer did not start the item");

    // The conversion loop never runs with an exhausted bit count.
    a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_CONV) |-> (bit_cnt_reg != '0))
        else $error("conversion loop ran past the last bit");

    // Digit scanning always has at least one digit left to send.
    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == STEP_SKIP) || (pc_reg == STEP_EMIT)) |-> (rem_reg != '0))
        else $error("digit scan with no digits left");
`endif

endmodule

`default_nettype wire
